// ===== hdl/tgr_pkg.sv =====
`timescale 1ns / 1ps

package tgr_pkg;

    localparam int TIME_W = 48;
    localparam int DUR_W  = 32;
    localparam int MS_W   = 16;
    // widest scaled threshold: 65535 * 1000 + 999 fits in 26 bits
    localparam int US_W   = 26;

    localparam int US_PER_MS = 1000;

    // floor(x / 1000) == (x * RECIP_M) >> RECIP_SHIFT for every 48-bit x
    localparam int           RECIP_SHIFT = 58;
    localparam logic [48:0]  RECIP_M     = 49'd288230376151712;

    typedef enum logic [1:0] {
        OP_FEED  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        G_NONE   = 2'd0,
        G_SINGLE = 2'd1,
        G_DOUBLE = 2'd2,
        G_LONG   = 2'd3
    } gesture_t;

    typedef enum logic [2:0] {
        M_IDLE  = 3'b001,
        M_PRESS = 3'b010,
        M_WAIT  = 3'b100
    } mode_t;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_LONG    = 2'd1;
    localparam logic [1:0] REG_TAP_MIN = 2'd2;
    localparam logic [1:0] REG_TAP_MAX = 2'd3;

    localparam logic [MS_W-1:0] RST_WINDOW_MS  = 16'd300;
    localparam logic [MS_W-1:0] RST_LONG_MS    = 16'd1000;
    localparam logic [MS_W-1:0] RST_TAP_MIN_MS = 16'd20;
    localparam logic [MS_W-1:0] RST_TAP_MAX_MS = 16'd500;

    localparam logic [US_W-1:0] RST_WINDOW_US  = US_W'(300 * US_PER_MS);
    localparam logic [US_W-1:0] RST_LONG_US    = US_W'(1000 * US_PER_MS);
    localparam logic [US_W-1:0] RST_TAP_MIN_US = US_W'(20 * US_PER_MS);
    localparam logic [US_W-1:0] RST_TAP_LIM_US = US_W'(500 * US_PER_MS + US_PER_MS - 1);

    // thresholds in microseconds, compared directly against raw time differences
    typedef struct packed {
        logic [US_W-1:0] win_us;
        logic [US_W-1:0] long_us;
        logic [US_W-1:0] min_us;
        logic [US_W-1:0] max_lim;
    } cfg_t;

    typedef struct packed {
        gesture_t            gesture;
        logic [TIME_W-1:0]   diff;
    } mid_t;

endpackage

// ===== hdl/tgr_if.sv =====
`timescale 1ns / 1ps

interface tgr_touch_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic        channel;
    logic        touched;
    logic [47:0] time_us;

    modport source (output valid, output opcode, output channel, output touched,
                    output time_us, input ready);
    modport sink   (input valid, input opcode, input channel, input touched,
                    input time_us, output ready);
endinterface

interface tgr_report_if;
    logic        valid;
    logic        ready;
    logic [1:0]  gesture;
    logic [31:0] press_ms;

    modport source (output valid, output gesture, output press_ms, input ready);
    modport sink   (input valid, input gesture, input press_ms, output ready);
endinterface

// ===== hdl/tgr_core.sv =====
`timescale 1ns / 1ps

module tgr_core
    import tgr_pkg::*;
#(
    parameter int CHANNELS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    tgr_touch_if.sink   touch,
    input  cfg_t        cfg,
    output logic        mid_valid,
    input  logic        mid_ready,
    output mid_t        mid
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                r0_valid_reg;
    opcode_t             r0_op_reg;
    logic                r0_ch_reg;
    logic                r0_touched_reg;
    logic [TIME_W-1:0]   r0_time_reg;

    mode_t               mode_reg [CHANNELS];
    logic [1:0]          tc_reg   [CHANNELS];
    logic [TIME_W-1:0]   ps_reg   [CHANNELS];
    logic [TIME_W-1:0]   rt_reg   [CHANNELS];
    logic [TIME_W-1:0]   ld_reg   [CHANNELS];

    logic                s1_valid_reg;
    mid_t                s1_reg;

    logic                s1_ready;
    logic                r0_fire;
    logic                accept;
    logic [IDX_W-1:0]    ch_idx;

    mode_t               cur_mode;
    logic [1:0]          cur_tc;
    logic [TIME_W-1:0]   cur_ps;
    logic [TIME_W-1:0]   cur_rt;
    logic [TIME_W-1:0]   cur_ld;
    logic [TIME_W-1:0]   gap;
    logic [TIME_W-1:0]   held;
    logic                timeout;
    logic                is_long;
    logic                in_tap;

    mode_t               mode_next;
    logic [1:0]          tc_next;
    logic [TIME_W-1:0]   ps_next;
    logic [TIME_W-1:0]   rt_next;
    logic [TIME_W-1:0]   ld_next;
    mid_t                s1_next;

    assign s1_ready    = !s1_valid_reg || mid_ready;
    assign r0_fire     = r0_valid_reg && s1_ready;
    assign touch.ready = !r0_valid_reg || s1_ready;
    assign accept      = touch.valid && touch.ready;

    assign mid_valid = s1_valid_reg;
    assign mid       = s1_reg;

    // channels beyond the configured count fold onto channel 0
    assign ch_idx = (int'(r0_ch_reg) < CHANNELS) ? IDX_W'(r0_ch_reg) : '0;

    assign cur_mode = mode_reg[ch_idx];
    assign cur_tc   = tc_reg[ch_idx];
    assign cur_ps   = ps_reg[ch_idx];
    assign cur_rt   = rt_reg[ch_idx];
    assign cur_ld   = ld_reg[ch_idx];

    // differences wrap modulo 2^48; ms thresholds are pre-scaled to us
    assign gap     = r0_time_reg - cur_rt;
    assign held    = r0_time_reg - cur_ps;
    assign timeout = (cur_mode == M_WAIT) && (gap >= TIME_W'(cfg.win_us));
    assign is_long = held >= TIME_W'(cfg.long_us);
    assign in_tap  = (held >= TIME_W'(cfg.min_us)) && (held <= TIME_W'(cfg.max_lim));

    always_comb
    begin
        mode_next       = cur_mode;
        tc_next         = cur_tc;
        ps_next         = cur_ps;
        rt_next         = cur_rt;
        ld_next         = cur_ld;
        s1_next.gesture = G_NONE;
        s1_next.diff    = cur_ld;

        unique case (r0_op_reg)
            OP_FEED:
            begin
                priority if (timeout)
                begin
                    // window expired: report the pending tap, drop this level
                    mode_next       = M_IDLE;
                    tc_next         = 2'd0;
                    s1_next.gesture = G_SINGLE;
                end
                else if (r0_touched_reg)
                begin
                    if (cur_mode != M_PRESS)
                    begin
                        if (cur_mode == M_WAIT)
                        begin
                            tc_next = 2'd2;
                        end
                        mode_next = M_PRESS;
                        ps_next   = r0_time_reg;
                        ld_next   = '0;
                    end
                end
                else
                begin
                    if (cur_mode == M_PRESS)
                    begin
                        priority if (is_long)
                        begin
                            mode_next       = M_IDLE;
                            tc_next         = 2'd0;
                            ld_next         = held;
                            s1_next.gesture = G_LONG;
                        end
                        else if (in_tap)
                        begin
                            if (cur_tc == 2'd0)
                            begin
                                tc_next   = 2'd1;
                                mode_next = M_WAIT;
                                rt_next   = r0_time_reg;
                                ld_next   = held;
                            end
                            else if (cur_tc == 2'd2)
                            begin
                                mode_next       = M_IDLE;
                                tc_next         = 2'd0;
                                ld_next         = held;
                                s1_next.gesture = G_DOUBLE;
                            end
                        end
                        else
                        begin
                            mode_next = M_IDLE;
                            tc_next   = 2'd0;
                            ld_next   = '0;
                        end
                    end
                end
                s1_next.diff = ld_next;
            end
            OP_READ:
            begin
                ld_next = '0;
            end
            OP_CLEAR:
            begin
                mode_next    = M_IDLE;
                tc_next      = 2'd0;
                ps_next      = '0;
                rt_next      = '0;
                ld_next      = '0;
                s1_next.diff = '0;
            end
            OP_NOP:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                mode_reg[i] <= M_IDLE;
                tc_reg[i]   <= 2'd0;
                ps_reg[i]   <= '0;
                rt_reg[i]   <= '0;
                ld_reg[i]   <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                r0_valid_reg <= 1'b1;
            end
            else if (r0_fire)
            begin
                r0_valid_reg <= 1'b0;
            end

            if (r0_fire)
            begin
                s1_valid_reg     <= 1'b1;
                mode_reg[ch_idx] <= mode_next;
                tc_reg[ch_idx]   <= tc_next;
                ps_reg[ch_idx]   <= ps_next;
                rt_reg[ch_idx]   <= rt_next;
                ld_reg[ch_idx]   <= ld_next;
            end
            else if (mid_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r0_op_reg      <= opcode_t'(touch.opcode);
            r0_ch_reg      <= touch.channel;
            r0_touched_reg <= touch.touched;
            r0_time_reg    <= touch.time_us;
        end
        if (r0_fire)
        begin
            s1_reg <= s1_next;
        end
    end

    a_double_needs_second_press: assert property (@(posedge clk) disable iff (!rst_n)
        r0_fire && s1_next.gesture == G_DOUBLE |-> cur_tc == 2'd2)
        else $error("double tap reported without a second press");

    a_wait_holds_one_tap: assert property (@(posedge clk) disable iff (!rst_n)
        r0_fire && cur_mode == M_WAIT |-> cur_tc == 2'd1)
        else $error("waiting for second tap with tap count other than one");

    a_clear_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        r0_fire && r0_op_reg == OP_CLEAR
        |=> s1_valid_reg && s1_reg.diff == '0 && s1_reg.gesture == G_NONE)
        else $error("channel reset did not report zero duration");

endmodule

// ===== hdl/tgr_div1000.sv =====
`timescale 1ns / 1ps

module tgr_div1000
    import tgr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mid_t          mid,
    tgr_report_if.source  report
);

    localparam int PP_LO_W = 16 + 25;
    localparam int PP_HI_W = 16 + 24;
    localparam int ROW_W   = 65;
    localparam int SUM_W   = 97;
    localparam int Q_W     = SUM_W - RECIP_SHIFT;

    logic                 a_valid_reg;
    gesture_t             a_gesture_reg;
    logic [PP_LO_W-1:0]   pp_lo_reg [3];
    logic [PP_HI_W-1:0]   pp_hi_reg [3];

    logic                 b_valid_reg;
    gesture_t             b_gesture_reg;
    logic [ROW_W-1:0]     row_reg [3];

    logic                 o_valid_reg;
    gesture_t             o_gesture_reg;
    logic [DUR_W-1:0]     o_dur_reg;

    logic                 a_ready;
    logic                 b_ready;
    logic                 o_ready;
    logic [SUM_W-1:0]     total;
    logic [Q_W-1:0]       quot;
    logic [DUR_W-1:0]     dur_next;

    assign o_ready  = !o_valid_reg || report.ready;
    assign b_ready  = !b_valid_reg || o_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign report.valid    = o_valid_reg;
    assign report.gesture  = o_gesture_reg;
    assign report.press_ms = o_dur_reg;

    // weight the three rows (one per 16-bit slice of x) by their offsets and take the integer part of x / 1000
    assign total = SUM_W'(row_reg[0])
                 + (SUM_W'(row_reg[1]) << 16)
                 + (SUM_W'(row_reg[2]) << 32);
    assign quot     = total[SUM_W-1:RECIP_SHIFT];
    assign dur_next = (|quot[Q_W-1:DUR_W]) ? '1 : quot[DUR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_gesture_reg <= mid.gesture;
            for (int i = 0; i < 3; i++)
            begin
                pp_lo_reg[i] <= PP_LO_W'(mid.diff[16*i +: 16]) * PP_LO_W'(RECIP_M[24:0]);
                pp_hi_reg[i] <= PP_HI_W'(mid.diff[16*i +: 16]) * PP_HI_W'(RECIP_M[48:25]);
            end
        end
        if (b_ready && a_valid_reg)
        begin
            b_gesture_reg <= a_gesture_reg;
            for (int i = 0; i < 3; i++)
            begin
                row_reg[i] <= ROW_W'(pp_lo_reg[i]) + (ROW_W'(pp_hi_reg[i]) << 25);
            end
        end
        if (o_ready && b_valid_reg)
        begin
            o_gesture_reg <= b_gesture_reg;
            o_dur_reg     <= dur_next;
        end
    end

endmodule

// ===== hdl/touch_gesture_recognizer.sv =====
// Two-channel tap, double-tap and long-press recognizer. Each request carries an
// opcode (feed a touch level, read and clear the last press duration, or reset
// the channel), a channel, a level and a 48-bit microsecond timestamp, and
// produces exactly one result: a gesture code and the channel's last press
// duration in milliseconds, saturated at 2^32-1. One request is taken every
// clock cycle while the output is not stalled. The rate is set by the
// per-channel record, which is read, updated and written back in the same
// cycle, in the stage after the input register; the divide by 1000 for the
// duration runs in a three-stage multiply pipeline that does not feed back into
// the state. Thresholds are programmed through the APB port in milliseconds;
// the user must see that they are written only while the block is idle, as the
// block does not enforce this. Channel state resets directly; there is no clearing pass.
`timescale 1ns / 1ps

module touch_gesture_recognizer
    import tgr_pkg::*;
#(
    parameter int CHANNELS = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    tgr_touch_if.sink     touch,
    tgr_report_if.source  report,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [MS_W-1:0]  window_ms_reg;
    logic [MS_W-1:0]  long_ms_reg;
    logic [MS_W-1:0]  tap_min_ms_reg;
    logic [MS_W-1:0]  tap_max_ms_reg;
    cfg_t             cfg_reg;

    logic             cfg_wr;
    logic [1:0]       reg_idx;
    logic [US_W-1:0]  wdata_us;

    logic             mid_valid;
    logic             mid_ready;
    mid_t             mid;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign reg_idx  = paddr[3:2];
    assign wdata_us = US_W'(pwdata[MS_W-1:0]) * US_W'(US_PER_MS);

    always_comb
    begin
        unique case (reg_idx)
            REG_WINDOW:  prdata = 32'(window_ms_reg);
            REG_LONG:    prdata = 32'(long_ms_reg);
            REG_TAP_MIN: prdata = 32'(tap_min_ms_reg);
            REG_TAP_MAX: prdata = 32'(tap_max_ms_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg   <= RST_WINDOW_MS;
            long_ms_reg     <= RST_LONG_MS;
            tap_min_ms_reg  <= RST_TAP_MIN_MS;
            tap_max_ms_reg  <= RST_TAP_MAX_MS;
            cfg_reg.win_us  <= RST_WINDOW_US;
            cfg_reg.long_us <= RST_LONG_US;
            cfg_reg.min_us  <= RST_TAP_MIN_US;
            cfg_reg.max_lim <= RST_TAP_LIM_US;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_WINDOW:
                begin
                    window_ms_reg  <= pwdata[MS_W-1:0];
                    cfg_reg.win_us <= wdata_us;
                end
                REG_LONG:
                begin
                    long_ms_reg     <= pwdata[MS_W-1:0];
                    cfg_reg.long_us <= wdata_us;
                end
                REG_TAP_MIN:
                begin
                    tap_min_ms_reg <= pwdata[MS_W-1:0];
                    cfg_reg.min_us <= wdata_us;
                end
                REG_TAP_MAX:
                begin
                    // store the last microsecond still inside the tap range
                    tap_max_ms_reg  <= pwdata[MS_W-1:0];
                    cfg_reg.max_lim <= wdata_us + US_W'(US_PER_MS - 1);
                end
                default:
                begin
                end
            endcase
        end
    end

    tgr_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .touch     (touch),
        .cfg       (cfg_reg),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid)
    );

    tgr_div1000 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mid_valid),
        .in_ready (mid_ready),
        .mid      (mid),
        .report   (report)
    );

endmodule

// ===== tb/sv/tb_touch_gesture_recognizer.sv =====
`timescale 1ns / 1ps

module tb_touch_gesture_recognizer;
    import tgr_pkg::*;

    typedef struct packed {
        opcode_t            opcode;
        logic               channel;
        logic               touched;
        logic [47:0]        time_us;
        logic               typed;
        gesture_t           want_gesture;
        logic [31:0]        want_ms;
    } touch_req_t;

    typedef struct packed {
        gesture_t           gesture;
        logic [31:0]        press_ms;
    } report_t;

    localparam logic [47:0] T_MAX      = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] T_BEFORE_0 = 48'hFFFF_FFF8_5EE0;    // 500 ms before wrap
    localparam int          PHASES     = 6;
    localparam int          PHASE_REQS = 125;
    localparam int          HOLD_CYCLES = 400;

    // rows with typed = 1 carry their own expectation; the rest use the predictor
    localparam touch_req_t DIRECTED [25] = '{
        '{OP_READ,  1'b0, 1'b0, 48'd0,          1'b1, G_NONE,   32'd0},
        '{OP_FEED,  1'b1, 1'b0, T_MAX,          1'b1, G_NONE,   32'd0},
        '{OP_FEED,  1'b0, 1'b1, 48'd0,          1'b1, G_NONE,   32'd0},
        '{OP_FEED,  1'b0, 1'b1, 48'd5000,       1'b1, G_NONE,   32'd0},
        '{OP_FEED,  1'b0, 1'b0, 48'd20000,      1'b1, G_NONE,   32'd20},
        '{OP_FEED,  1'b0, 1'b1, 48'd319999,     1'b0, G_NONE,   32'd0},
        '{OP_FEED,  1'b0, 1'b0, 48'd820998,     1'b1, G_DOUBLE, 32'd500},
        '{OP_FEED,  1'b0, 1'b1, 48'd1000000,    1'b0, G_NONE,   32'd0},
        '{OP_FEED,  1'b0, 1'b0, 48'd1030000,    1'b0, G_NONE,   32'd0},
        '{OP_FEED,  1'b0, 1'b0, 48'd1330000,    1'b1, G_SINGLE, 32'd30},
        '{OP_FEED,  1'b1, 1'b1, T_BEFORE_0,     1'b0, G_NONE,   32'd0},
        '{OP_FEED,  1'b1, 1'b0, 48'd1000000,    1'b1, G_LONG,   32'd1500},
        '{OP_READ,  1'b1, 1'b1, 48'd0,          1'b1, G_NONE,   32'd1500},
        '{OP_READ,  1'b1, 1'b0, 48'd0,          1'b1, G_NONE,   32'd0},
        '{OP_FEED,  1'b1, 1'b1, 48'd2000000,    1'b0, G_NONE,   32'd0},
        '{OP_FEED,  1'b1, 1'b0, 48'd2019999,    1'b1, G_NONE,   32'd0},
        '{OP_FEED,  1'b1, 1'b1, 48'd3000000,    1'b0, G_NONE,   32'd0},
        '{OP_FEED,  1'b1, 1'b0, 48'd3999999,    1'b1, G_NONE,   32'd0},
        '{OP_FEED,  1'b0, 1'b1, 48'd0,          1'b0, G_NONE,   32'd0},
        '{OP_FEED,  1'b0, 1'b0, T_MAX,          1'b1, G_LONG,   32'hFFFF_FFFF},
        '{OP_NOP,   1'b0, 1'b1, 48'h1234_5678,  1'b1, G_NONE,   32'hFFFF_FFFF},
        '{OP_FEED,  1'b1, 1'b1, 48'd100,        1'b0, G_NONE,   32'd0},
        '{OP_CLEAR, 1'b1, 1'b1, 48'd150,        1'b1, G_NONE,   32'd0},
        '{OP_FEED,  1'b1, 1'b0, 48'd200000,     1'b1, G_NONE,   32'd0},
        '{OP_CLEAR, 1'b0, 1'b0, T_MAX,          1'b1, G_NONE,   32'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tgr_touch_if  touch_bus ();
    tgr_report_if report_bus ();

    touch_gesture_recognizer #(.CHANNELS(2)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .touch   (touch_bus),
        .report  (report_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the thresholds and of the per-channel gesture records
    logic [15:0] win_ms;
    logic [15:0] long_ms;
    logic [15:0] tap_min_ms;
    logic [15:0] tap_max_ms;
    mode_t       chan_mode     [2];
    logic [1:0]  chan_taps     [2];
    logic [47:0] chan_press_t  [2];
    logic [47:0] chan_release_t[2];
    logic [31:0] chan_last_ms  [2];
    logic [47:0] chan_clock    [2];

    report_t     pending_reports[$];
    report_t     oldest_report;
    int          mismatches = 0;
    int          reqs_sent;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_request;
    logic        hold_taken;
    int          hold_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [31:0] ms_between(logic [47:0] now_us, logic [47:0] then_us);
        logic [47:0] q;
        q = (now_us - then_us) / 48'd1000;
        return (q > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic void clear_channel(logic ch);
        chan_mode[ch]      = M_IDLE;
        chan_taps[ch]      = 2'd0;
        chan_press_t[ch]   = '0;
        chan_release_t[ch] = '0;
        chan_last_ms[ch]   = '0;
    endfunction

    function automatic gesture_t recognize(logic ch, logic touched, logic [47:0] t);
        logic [31:0] held_ms;
        // a late feed while waiting ends the first tap and is dropped
        if (chan_mode[ch] == M_WAIT && ms_between(t, chan_release_t[ch]) >= 32'(win_ms))
        begin
            chan_mode[ch] = M_IDLE;
            chan_taps[ch] = 2'd0;
            return G_SINGLE;
        end
        if (touched)
        begin
            if (chan_mode[ch] != M_PRESS)
            begin
                if (chan_mode[ch] == M_WAIT)
                    chan_taps[ch] = 2'd2;
                chan_mode[ch]    = M_PRESS;
                chan_press_t[ch] = t;
                chan_last_ms[ch] = '0;
            end
            return G_NONE;
        end
        if (chan_mode[ch] != M_PRESS)
            return G_NONE;
        held_ms = ms_between(t, chan_press_t[ch]);
        if (held_ms >= 32'(long_ms))
        begin
            chan_mode[ch]    = M_IDLE;
            chan_taps[ch]    = 2'd0;
            chan_last_ms[ch] = held_ms;
            return G_LONG;
        end
        if (held_ms >= 32'(tap_min_ms) && held_ms <= 32'(tap_max_ms))
        begin
            if (chan_taps[ch] == 2'd0)
            begin
                chan_taps[ch]      = 2'd1;
                chan_mode[ch]      = M_WAIT;
                chan_release_t[ch] = t;
                chan_last_ms[ch]   = held_ms;
            end
            else if (chan_taps[ch] == 2'd2)
            begin
                chan_mode[ch]    = M_IDLE;
                chan_taps[ch]    = 2'd0;
                chan_last_ms[ch] = held_ms;
                return G_DOUBLE;
            end
            return G_NONE;
        end
        chan_mode[ch]    = M_IDLE;
        chan_taps[ch]    = 2'd0;
        chan_last_ms[ch] = '0;
        return G_NONE;
    endfunction

    function automatic report_t predict_report(touch_req_t r);
        report_t res;
        res.gesture = G_NONE;
        case (r.opcode)
            OP_FEED:
            begin
                res.gesture  = recognize(r.channel, r.touched, r.time_us);
                res.press_ms = chan_last_ms[r.channel];
            end
            OP_READ:
            begin
                res.press_ms            = chan_last_ms[r.channel];
                chan_last_ms[r.channel] = '0;
            end
            OP_CLEAR:
            begin
                clear_channel(r.channel);
                res.press_ms = '0;
            end
            default:
                res.press_ms = chan_last_ms[r.channel];
        endcase
        return res;
    endfunction

    // spans mostly cluster around the current thresholds to hit both sides of each; the rest are random
    function automatic logic [47:0] pick_span_us();
        int ms;
        case ($urandom_range(0, 5))
            0:       ms = int'(win_ms);
            1:       ms = int'(long_ms);
            2:       ms = int'(tap_min_ms);
            3:       ms = int'(tap_max_ms);
            4:       ms = int'($urandom_range(0, 100));
            default: ms = int'($urandom_range(0, 70000));
        endcase
        ms = ms + int'($urandom_range(0, 4)) - 2;
        if (ms < 0)
            ms = 0;
        return 48'(ms) * 48'd1000 + ($urandom_range(0, 1) ? 48'($urandom_range(0, 999)) : 48'd0);
    endfunction

    task automatic offer(input touch_req_t r);
        report_t want;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            touch_bus.valid = 1'b0;
            @(negedge clk);
        end
        touch_bus.valid   = 1'b1;
        touch_bus.opcode  = r.opcode;
        touch_bus.channel = r.channel;
        touch_bus.touched = r.touched;
        touch_bus.time_us = r.time_us;
        @(posedge clk);
        while (!touch_bus.ready)
            @(posedge clk);
        want = predict_report(r);
        if (r.typed)
        begin
            want.gesture  = r.want_gesture;
            want.press_ms = r.want_ms;
        end
        pending_reports = {pending_reports, want};
        reqs_sent++;
    endtask

    task automatic issue(opcode_t op, logic ch, logic touched);
        offer('{op, ch, touched, chan_clock[ch], 1'b0, G_NONE, 32'd0});
    endtask

    task automatic gesture_burst();
        logic        ch;
        int unsigned pick;
        ch   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            chan_clock[ch] = 48'({$urandom, $urandom});
        chan_clock[ch] += pick_span_us();
        if (pick < 45)
        begin
            issue(OP_FEED, ch, 1'b1);
            chan_clock[ch] += pick_span_us();
            issue(OP_FEED, ch, 1'b0);
        end
        else if (pick < 70)
        begin
            repeat (2)
            begin
                issue(OP_FEED, ch, 1'b1);
                chan_clock[ch] += pick_span_us();
                issue(OP_FEED, ch, 1'b0);
                chan_clock[ch] += pick_span_us();
            end
        end
        else if (pick < 78)
            issue(OP_FEED, ch, 1'($urandom_range(0, 1)));
        else if (pick < 84)
            issue(OP_READ, ch, 1'($urandom_range(0, 1)));
        else if (pick < 88)
            issue(OP_CLEAR, ch, 1'($urandom_range(0, 1)));
        else if (pick < 91)
            issue(OP_NOP, ch, 1'($urandom_range(0, 1)));
        else
            offer('{opcode_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 48'({$urandom, $urandom}), 1'b0, G_NONE, 32'd0});
    endtask

    task automatic drain();
        @(negedge clk);
        touch_bus.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'($urandom), val};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_WINDOW:  win_ms     = val;
            REG_LONG:    long_ms    = val;
            REG_TAP_MIN: tap_min_ms = val;
            default:     tap_max_ms = val;
        endcase
    endtask

    task automatic write_thresholds(logic [15:0] w, logic [15:0] l, logic [15:0] mn,
                                    logic [15:0] mx);
        write_reg(REG_WINDOW, w);
        write_reg(REG_LONG, l);
        write_reg(REG_TAP_MIN, mn);
        write_reg(REG_TAP_MAX, mx);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        report_bus.ready = 1'b0;
        hold_left        = 0;
        hold_taken       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                report_bus.ready = 1'b0;
                hold_left--;
            end
            else
                report_bus.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic void note_mismatch(string what);
        if (mismatches < 10)
            $display("%t mismatch: %s", $realtime, what);
        mismatches++;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && report_bus.valid && report_bus.ready)
        begin
            if (pending_reports.size() == 0)
                note_mismatch($sformatf("unexpected report gesture=%0d press_ms=%0d",
                                        report_bus.gesture, report_bus.press_ms));
            else
            begin
                oldest_report = pending_reports.pop_front();
                if (report_bus.gesture != oldest_report.gesture)
                    note_mismatch($sformatf("gesture expected %0d got %0d",
                                            oldest_report.gesture, report_bus.gesture));
                if (report_bus.press_ms != oldest_report.press_ms)
                    note_mismatch($sformatf("press_ms expected %0d got %0d",
                                            oldest_report.press_ms, report_bus.press_ms));
            end
        end
    end

    initial
    begin
        int target;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        touch_bus.valid   = 1'b0;
        touch_bus.opcode  = '0;
        touch_bus.channel = 1'b0;
        touch_bus.touched = 1'b0;
        touch_bus.time_us = '0;
        hold_request      = 1'b0;
        reqs_sent         = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        win_ms            = RST_WINDOW_MS;
        long_ms           = RST_LONG_MS;
        tap_min_ms        = RST_TAP_MIN_MS;
        tap_max_ms        = RST_TAP_MAX_MS;
        clear_channel(1'b0);
        clear_channel(1'b1);
        chan_clock[0] = '0;
        chan_clock[1] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            offer(DIRECTED[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                case (p)
                    1: write_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
                    2: write_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    3: write_thresholds(16'd5, 16'd50, 16'd2, 16'd20);
                    4: write_thresholds(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 3000)),
                                        16'($urandom_range(0, 300)), 16'($urandom_range(0, 1000)));
                    default: write_thresholds(16'($urandom), 16'($urandom),
                                              16'($urandom), 16'($urandom));
                endcase
            end
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            // stall the result side while requests keep coming, so the input backs up
            if (p == 4)
                hold_request = 1'b1;
            target = reqs_sent + PHASE_REQS;
            while (reqs_sent < target)
                gesture_burst();
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tgr_pkg.sv
hdl/tgr_if.sv
hdl/tgr_core.sv
hdl/tgr_div1000.sv
hdl/touch_gesture_recognizer.sv
tb/sv/tb_touch_gesture_recognizer.sv
